[sv/ddfp_pkg.sv]
// Shared types and constants for the delimited decimal field parser.
// Used by ddfp_char_step, ddfp_out_buf and delimited_decimal_field_parser.
package ddfp_pkg;

    // Register map (word index, paddr[3:2])
    localparam logic [1:0] REG_START      = 2'd0;
    localparam logic [1:0] REG_SEPARATOR  = 2'd1;
    localparam logic [1:0] REG_TERMINATOR = 2'd2;

    localparam logic [7:0] START_RESET      = 8'd42;  // '*'
    localparam logic [7:0] SEPARATOR_RESET  = 8'd44;  // ','
    localparam logic [7:0] TERMINATOR_RESET = 8'd35;  // '#'

    // Character codes used by the number scanner
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [15:0] VALUE_MAX = 16'hFFFF;

    // Scanner phase: before the number, inside sign/digits, finished.
    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_NUM  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [15:0] acc;
        logic        saturated;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase: PH_PRE, negative: 1'b0, acc: 16'd0, saturated: 1'b0};

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  number;
        logic        last;
        logic        saturated;
        logic        clipped;
    } result_t;

endpackage

[sv/ddfp_char_step.sv]
// Applies one field character to the atol-style number scanner.
// Purely combinational; uses types and constants from ddfp_pkg.
module ddfp_char_step (
    input  logic [7:0]           char_in,
    input  ddfp_pkg::scan_state_t cur,
    output ddfp_pkg::scan_state_t nxt
);

    logic        is_digit;
    logic        is_space;
    logic        is_sign;
    logic [3:0]  digit_val;
    logic [19:0] times_ten;
    logic [19:0] sum;

    assign is_digit  = (char_in >= ddfp_pkg::CHAR_ZERO) && (char_in <= ddfp_pkg::CHAR_NINE);
    assign is_space  = (char_in == ddfp_pkg::CHAR_SPACE) ||
                       ((char_in >= ddfp_pkg::CHAR_TAB) && (char_in <= ddfp_pkg::CHAR_CR));
    assign is_sign   = (char_in == ddfp_pkg::CHAR_PLUS) || (char_in == ddfp_pkg::CHAR_MINUS);
    assign digit_val = 4'(char_in - ddfp_pkg::CHAR_ZERO);

    // acc * 10 as (acc << 3) + (acc << 1); fits in 20 bits with the digit added.
    assign times_ten = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
    assign sum       = times_ten + {16'd0, digit_val};

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase) inside
            ddfp_pkg::PH_PRE,
            ddfp_pkg::PH_NUM:
            begin
                if (is_digit)
                begin
                    nxt.phase = ddfp_pkg::PH_NUM;
                    if (sum > {4'd0, ddfp_pkg::VALUE_MAX})
                    begin
                        nxt.acc       = ddfp_pkg::VALUE_MAX;
                        nxt.saturated = 1'b1;
                    end
                    else
                    begin
                        nxt.acc = sum[15:0];
                    end
                end
                else if ((cur.phase == ddfp_pkg::PH_PRE) && is_space)
                begin
                    nxt = cur;
                end
                else if ((cur.phase == ddfp_pkg::PH_PRE) && is_sign)
                begin
                    nxt.negative = (char_in == ddfp_pkg::CHAR_MINUS);
                    nxt.phase    = ddfp_pkg::PH_NUM;
                end
                else
                begin
                    nxt.phase = ddfp_pkg::PH_DONE;
                end
            end
            ddfp_pkg::PH_DONE:
            begin
                nxt = cur;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[sv/ddfp_out_buf.sv]
// Two-entry result buffer (output register plus skid register).
// Uses ddfp_pkg::result_t; full is registered so the input stall never waits on res_stall.
module ddfp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ddfp_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output ddfp_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    ddfp_pkg::result_t out_data_reg;
    ddfp_pkg::result_t skid_data_reg;
    logic              taken;

    assign taken     = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (taken)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !taken)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (taken)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !taken)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    // The skid entry is only ever occupied behind a held output entry.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // A push that meets a stalled output must land in the skid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost on a stalled output");

endmodule

[sv/delimited_decimal_field_parser.sv]
// Top level of the delimited decimal field parser.
// Depends on ddfp_pkg, ddfp_char_step and ddfp_out_buf.
//
// The parser takes one received byte per clock cycle on the rx channel and splits a frame
// such as *101,50# into numbered decimal fields. The start and separator bytes open a field
// (closing and reporting any field already open), and the terminator byte closes the open
// field, reports it with frame_last set and returns the parser to idle. Each field is scanned
// like atol: leading white space is skipped, one sign is taken, and digits are read up to the
// first other byte. The magnitude clips at 65535 with value_saturated set, and a minus sign
// negates modulo 65536; past MAX_FIELDS fields the number holds at MAX_FIELDS-1 with
// index_clipped set. Every byte is applied to the field state in the cycle it is accepted, so
// the sustained rate is one byte per cycle while rx_stall is low; the byte that closes a field
// registers its result into a two-entry buffer. rx_stall rises only when a result is held in
// the skid entry behind a stalled output, and that stall clears the cycle after the output is
// taken. The three delimiter codes are APB registers at byte addresses 0, 4 and 8 and should
// be written only while the parser is idle.
module delimited_decimal_field_parser #(
    parameter int MAX_FIELDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received bytes
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    // field results
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] field_value,
    output logic [3:0]  field_number,
    output logic        frame_last,
    output logic        value_saturated,
    output logic        index_clipped
);

    // The counter must be able to hold MAX_FIELDS itself, which marks a clipped field.
    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_FIELDS);
    localparam logic [CW-1:0] CNT_TOP   = CW'(MAX_FIELDS - 1);

    logic [7:0]  start_reg;
    logic [7:0]  separator_reg;
    logic [7:0]  terminator_reg;

    logic                  open_reg;
    logic [CW-1:0]         counter_reg;
    ddfp_pkg::scan_state_t scan_reg;
    ddfp_pkg::scan_state_t scan_next;

    logic              accept;
    logic              is_open_cmd;
    logic              is_term;
    logic              emit;
    logic              clipped;
    logic [CW-1:0]     number_sat;
    logic [CW+3:0]     number_ext;
    logic [15:0]       value_signed;
    ddfp_pkg::result_t result;
    ddfp_pkg::result_t out_data;
    logic              buf_full;
    logic              cfg_write;

    // ---------------------------------------------------------------- configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= ddfp_pkg::START_RESET;
            separator_reg  <= ddfp_pkg::SEPARATOR_RESET;
            terminator_reg <= ddfp_pkg::TERMINATOR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                ddfp_pkg::REG_START:      start_reg      <= pwdata[7:0];
                ddfp_pkg::REG_SEPARATOR:  separator_reg  <= pwdata[7:0];
                ddfp_pkg::REG_TERMINATOR: terminator_reg <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ddfp_pkg::REG_START:      prdata = {24'd0, start_reg};
            ddfp_pkg::REG_SEPARATOR:  prdata = {24'd0, separator_reg};
            ddfp_pkg::REG_TERMINATOR: prdata = {24'd0, terminator_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- byte classification
    // Start and separator are checked together, and both before the terminator, so a byte that
    // matches several registers acts as an opening delimiter.
    assign accept      = rx_valid && !rx_stall;
    assign is_open_cmd = (rx_byte == start_reg) || (rx_byte == separator_reg);
    assign is_term     = !is_open_cmd && (rx_byte == terminator_reg);
    assign emit        = accept && open_reg && (is_open_cmd || is_term);

    ddfp_char_step u_char_step (
        .char_in (rx_byte),
        .cur     (scan_reg),
        .nxt     (scan_next)
    );

    // ---------------------------------------------------------------- result of the open field
    assign clipped      = (counter_reg >= CNT_LIMIT);
    assign number_sat   = clipped ? CNT_TOP : counter_reg;
    assign number_ext   = {4'd0, number_sat};
    assign value_signed = scan_reg.negative ? (16'd0 - scan_reg.acc) : scan_reg.acc;

    always_comb
    begin
        result.value     = value_signed;
        result.number    = number_ext[3:0];
        result.last      = is_term;
        result.saturated = scan_reg.saturated;
        result.clipped   = clipped;
    end

    // ---------------------------------------------------------------- field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            counter_reg <= '0;
            scan_reg    <= ddfp_pkg::SCAN_CLEAR;
        end
        else if (accept)
        begin
            if (is_open_cmd)
            begin
                // Inside a frame numbering continues; otherwise a new frame starts at zero.
                open_reg <= 1'b1;
                scan_reg <= ddfp_pkg::SCAN_CLEAR;
                if (!open_reg)
                begin
                    counter_reg <= '0;
                end
                else if (counter_reg < CNT_LIMIT)
                begin
                    counter_reg <= counter_reg + CW'(1);
                end
            end
            else if (is_term)
            begin
                // A terminator with no field open is ignored.
                if (open_reg)
                begin
                    open_reg    <= 1'b0;
                    counter_reg <= '0;
                    scan_reg    <= ddfp_pkg::SCAN_CLEAR;
                end
            end
            else if (open_reg)
            begin
                scan_reg <= scan_next;
            end
        end
    end

    // ---------------------------------------------------------------- result buffer
    ddfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .full      (buf_full),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_data  (out_data)
    );

    assign rx_stall        = buf_full;
    assign field_value     = out_data.value;
    assign field_number    = out_data.number;
    assign frame_last      = out_data.last;
    assign value_saturated = out_data.saturated;
    assign index_clipped   = out_data.clipped;

    // ---------------------------------------------------------------- assertions
    // The field counter never runs past the clipped marker.
    assert property (@(posedge clk) disable iff (!rst_n) counter_reg <= CNT_LIMIT)
        else $error("field counter beyond MAX_FIELDS");

    // Between frames the counter and the scanner are back at their cleared values.
    assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> ((counter_reg == '0) && (scan_reg == ddfp_pkg::SCAN_CLEAR)))
        else $error("field state not cleared while idle");

    // A terminator on an open field always closes it, and res_valid is high on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && open_reg && is_term) |=> (res_valid && !open_reg))
        else $error("terminator did not close the field");

endmodule
